// ===== hw/rtl/iemq_pkg.sv =====
`timescale 1ns / 1ps

package iemq_pkg;

    localparam int CAPACITY = 16;
    localparam int PTR_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] CMD_WHEEL = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_POLL  = 2'd2;

    localparam logic [2:0] KEY_LEFT  = 3'd0;
    localparam logic [2:0] KEY_RIGHT = 3'd1;
    localparam logic [2:0] KEY_SPACE = 3'd2;
    localparam logic [2:0] KEY_ENTER = 3'd3;

    localparam logic [1:0] KIND_TURN = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    typedef enum logic [1:0] {
        OP_IGNORE,
        OP_ACK,
        OP_PUSH,
        OP_POLL
    } op_code_t;

    typedef enum logic {
        BK_RUN,
        BK_POLL
    } back_state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        stamp;
        logic signed [16:0] amount;
    } event_t;

    typedef struct packed {
        op_code_t code;
        event_t   ev;
    } op_t;

    typedef struct packed {
        logic   accepted;
        event_t ev;
    } res_t;

    typedef struct packed {
        logic       poll_busy;
        logic [1:0] res_count;
    } back_status_t;

endpackage

// ===== hw/rtl/iemq_front.sv =====
`timescale 1ns / 1ps

module iemq_front
    import iemq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         command,
    input  logic signed [23:0] wheel_delta,
    input  logic [2:0]         key_code,
    input  logic               key_down,
    input  logic               key_repeat,
    input  logic [31:0]        stamp_in,
    output logic               op_push,
    output op_t                op
);

    logic        space_held_reg;
    logic        space_held_next;
    logic        enter_held_reg;
    logic        enter_held_next;
    logic        accept;
    logic [23:0] raw;
    logic [23:0] mag;
    logic [24:0] rounded;
    logic [16:0] whole;
    logic        held_now;
    logic        was_down;
    logic        is_down;

    assign accept  = push && !full;
    assign op_push = accept;

    // ceiling of the magnitude over 256, then the sign back on
    assign raw     = wheel_delta;
    assign mag     = raw[23] ? (24'd0 - raw) : raw;
    assign rounded = {1'b0, mag} + 25'd255;
    assign whole   = rounded[24:8];

    always_comb
    begin
        space_held_next = space_held_reg;
        enter_held_next = enter_held_reg;
        op.code         = OP_IGNORE;
        op.ev.kind      = KIND_TURN;
        op.ev.stamp     = stamp_in;
        op.ev.amount    = '0;
        held_now        = (key_code == KEY_SPACE) ? space_held_reg : enter_held_reg;
        was_down        = space_held_reg || enter_held_reg;
        is_down         = was_down;
        unique case (command)
            CMD_WHEEL:
            begin
                if (raw != 24'd0)
                begin
                    op.code      = OP_PUSH;
                    op.ev.amount = raw[23] ? (17'sd0 - $signed(whole)) : $signed(whole);
                end
            end
            CMD_KEY:
            begin
                if (key_code == KEY_LEFT || key_code == KEY_RIGHT)
                begin
                    if (key_down)
                    begin
                        op.code      = OP_PUSH;
                        op.ev.amount = (key_code == KEY_LEFT) ? -17'sd1 : 17'sd1;
                    end
                end
                else if ((key_code == KEY_SPACE || key_code == KEY_ENTER) && !key_repeat
                         && held_now != key_down)
                begin
                    if (key_code == KEY_SPACE)
                    begin
                        space_held_next = key_down;
                    end
                    else
                    begin
                        enter_held_next = key_down;
                    end
                    is_down = space_held_next || enter_held_next;
                    if (was_down == is_down)
                    begin
                        op.code = OP_ACK;
                    end
                    else
                    begin
                        op.code    = OP_PUSH;
                        op.ev.kind = is_down ? KIND_DOWN : KIND_UP;
                    end
                end
            end
            CMD_POLL:
            begin
                op.code = OP_POLL;
            end
            default:
            begin
                op.code = OP_IGNORE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_held_reg <= 1'b0;
            enter_held_reg <= 1'b0;
        end
        else if (accept)
        begin
            space_held_reg <= space_held_next;
            enter_held_reg <= enter_held_next;
        end
    end

endmodule

// ===== hw/rtl/iemq_op_queue.sv =====
`timescale 1ns / 1ps

module iemq_op_queue
    import iemq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  op_t  wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output op_t  rd_data
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/iemq_back.sv =====
`timescale 1ns / 1ps

module iemq_back
    import iemq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    input  op_t          op,
    output logic         op_pop,
    input  logic         pop,
    output logic         empty,
    output res_t         res,
    output back_status_t status
);

    event_t      ring_mem [CAPACITY];
    event_t      rd_data_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    back_state_t state_reg;
    back_state_t state_next;
    logic        ring_full;
    logic        ring_empty;
    logic        mem_we;
    logic        mem_re;

    res_t        res_q_reg [2];
    logic        res_wr_ptr_reg;
    logic        res_rd_ptr_reg;
    logic [1:0]  res_count_reg;
    logic [1:0]  res_count_next;
    logic        res_wr;
    res_t        res_wr_data;
    logic        res_rd;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(CAPACITY - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(CAPACITY - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign ring_full  = (wr_ptr_inc == rd_ptr_reg);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);

    assign empty  = (res_count_reg == 2'd0);
    assign res    = res_q_reg[res_rd_ptr_reg];
    assign res_rd = pop && !empty;

    assign status.poll_busy = (state_reg == BK_POLL);
    assign status.res_count = res_count_reg;

    always_comb
    begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        op_pop      = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        res_wr      = 1'b0;
        res_wr_data = '0;
        unique case (state_reg)
            BK_RUN:
            begin
                // a slot in the result queue is needed before an op is taken
                if (op_valid && res_count_reg != 2'd2)
                begin
                    op_pop = 1'b1;
                    unique case (op.code)
                        OP_IGNORE:
                        begin
                            res_wr = 1'b1;
                        end
                        OP_ACK:
                        begin
                            res_wr               = 1'b1;
                            res_wr_data.accepted = 1'b1;
                        end
                        OP_PUSH:
                        begin
                            res_wr = 1'b1;
                            if (!ring_full)
                            begin
                                mem_we               = 1'b1;
                                wr_ptr_next          = wr_ptr_inc;
                                res_wr_data.accepted = 1'b1;
                            end
                        end
                        OP_POLL:
                        begin
                            if (ring_empty)
                            begin
                                res_wr = 1'b1;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                rd_ptr_next = rd_ptr_inc;
                                state_next  = BK_POLL;
                            end
                        end
                        default:
                        begin
                            res_wr = 1'b1;
                        end
                    endcase
                end
            end
            BK_POLL:
            begin
                // slot was reserved when the poll was taken
                res_wr               = 1'b1;
                res_wr_data.accepted = 1'b1;
                res_wr_data.ev       = rd_data_reg;
                state_next           = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        res_count_next = res_count_reg;
        if (res_wr && !res_rd)
        begin
            res_count_next = res_count_reg + 2'd1;
        end
        else if (res_rd && !res_wr)
        begin
            res_count_next = res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_RUN;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            res_count_reg <= res_count_next;
            if (res_wr)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_rd)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_ptr_reg] <= op.ev;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
        if (res_wr)
        begin
            res_q_reg[res_wr_ptr_reg] <= res_wr_data;
        end
    end

endmodule

// ===== hw/rtl/input_event_mapper_queue.sv =====
`timescale 1ns / 1ps
// input event mapper with a timestamped event ring
// input channel: a command transaction moves when push is high and full is low;
//   wheel and key commands are turned into turn or button events and queued with
//   stamp_in, a poll command takes the oldest queued event out again
// result channel: one result per command, oldest first, shown while empty is low
//   and taken when pop is high; accepted carries the command's outcome and the
//   event fields are zero unless a poll delivered an event
// the front decodes a command in its accept cycle and keeps the space/enter held
//   flags; a two-entry op queue sits between it and the back, which owns the ring
//   (CAPACITY entries, CAPACITY-1 usable) and a two-entry result queue
// a result passes the op queue and then the result queue; a poll that hits a non-empty
//   ring also waits in the back's poll state for the registered ring read
// throughput: one command per cycle while full is low; the back takes no new op
//   while it waits in its poll state for the registered ring read
// reset clears pointers, held flags and both queues; ring contents are left as is
// when the receiver stops popping, the result queue fills, the back stops taking
//   ops, the op queue fills and full rises
module input_event_mapper_queue
    import iemq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         command,
    input  logic signed [23:0] wheel_delta,
    input  logic [2:0]         key_code,
    input  logic               key_down,
    input  logic               key_repeat,
    input  logic [31:0]        stamp_in,
    output logic               empty,
    input  logic               pop,
    output logic               accepted,
    output logic [1:0]         event_kind,
    output logic [31:0]        event_stamp,
    output logic signed [16:0] event_amount
);

    logic         op_push;
    op_t          op_in;
    logic         op_pop;
    logic         op_valid;
    op_t          op_out;
    res_t         res;
    back_status_t status;

    iemq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .wheel_delta(wheel_delta),
        .key_code   (key_code),
        .key_down   (key_down),
        .key_repeat (key_repeat),
        .stamp_in   (stamp_in),
        .op_push    (op_push),
        .op         (op_in)
    );

    iemq_op_queue u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (op_in),
        .full    (full),
        .rd_en   (op_pop),
        .rd_valid(op_valid),
        .rd_data (op_out)
    );

    iemq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_valid(op_valid),
        .op      (op_out),
        .op_pop  (op_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res),
        .status  (status)
    );

    assign accepted     = res.accepted;
    assign event_kind   = res.ev.kind;
    assign event_stamp  = res.ev.stamp;
    assign event_amount = res.ev.amount;

    // ring read finishes in the cycle after the poll is taken
    a_poll_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        status.poll_busy |=> !status.poll_busy)
        else $error("poll read did not complete in one cycle");

    // a poll in flight always has its result slot reserved
    a_poll_slot: assert property (@(posedge clk) disable iff (!rst_n)
        status.poll_busy |-> status.res_count != 2'd2)
        else $error("poll in flight without a free result slot");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        empty == (status.res_count == 2'd0))
        else $error("empty does not match result queue fill");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (status.res_count == 2'd2 && !pop) |=> status.res_count == 2'd2)
        else $error("result queue changed fill while full and stalled");

endmodule
